// File: sv/tuid_pkg.sv
// Shared types and constants of the time-ordered unique id generator.
// Depends on nothing; used by the slot table, the top level and the checker.
package tuid_pkg;

    // Field and table sizes
    localparam int NUM_SLOTS   = 128;
    localparam int SLOT_BITS   = $clog2(NUM_SLOTS);
    localparam int REQ_BITS    = 8;
    localparam int TIME_BITS   = 41;
    localparam int COUNT_BITS  = 12;
    localparam int WORKER_BITS = 10;
    localparam int ID_BITS     = 63;
    localparam int STATUS_BITS = 2;

    // Stream word widths, packed and padded to whole bytes
    localparam int S_FIELD_BITS = REQ_BITS + TIME_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = ID_BITS + STATUS_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BEHIND    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EXHAUSTED = 2'd2;

    // Largest count within one millisecond
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // One slot table entry
    typedef struct packed {
        logic [TIME_BITS-1:0]  last_time;
        logic [COUNT_BITS-1:0] count;
    } slot_entry_t;

endpackage

// File: sv/tuid_slot_table.sv
// Per-slot table of last time and sequence count, with registered read.
// Depends on tuid_pkg. Forwards a write that lands on the slot being read.
module tuid_slot_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [tuid_pkg::SLOT_BITS-1:0] rd_addr,
    output tuid_pkg::slot_entry_t         rd_data,
    input  logic                          wr_en,
    input  logic [tuid_pkg::SLOT_BITS-1:0] wr_addr,
    input  tuid_pkg::slot_entry_t         wr_data
);
    import tuid_pkg::*;

    slot_entry_t           mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  valid_reg;
    slot_entry_t           mem_q_reg;
    logic                  rd_valid_reg;
    logic                  fwd_hit_reg;
    slot_entry_t           fwd_data_reg;

    // Write the entry, read the addressed entry into the output register
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Prefer the write that happened in the same cycle as the read
    always_comb begin
        if (fwd_hit_reg) begin
            rd_data = fwd_data_reg;
        end else if (rd_valid_reg) begin
            rd_data = mem_q_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

// File: sv/time_ordered_unique_id_generator.sv
// Top level of the time-ordered unique id generator.
// Depends on tuid_pkg and tuid_slot_table.
//
// Each request word carries a slot number and the current time in milliseconds;
// each result word carries a 63-bit id (time, worker id, count) and a status.
// The block takes one request per clock while the result side does not stall.
// The request stage registers the request and the slot table read on acceptance;
// the update and the result are registered as it advances. Requests to the same
// slot in consecutive cycles are served at full rate because the table write is
// forwarded into the next read.
// The 128-entry table starts cleared through per-entry valid bits, so no
// clearing pass is needed after reset. A status other than ok (clock behind,
// counts of this millisecond used up) returns a zero id and leaves the table
// unchanged; the caller retries. Write worker_id only while the block is idle.
module time_ordered_unique_id_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: worker_id
    input  logic                              cfg_we,
    input  logic [tuid_pkg::WORKER_BITS-1:0]  cfg_wdata,
    // request: [7:0] counter_slot, [48:8] now_ms, rest zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tuid_pkg::S_DATA_BITS-1:0]  s_tdata,
    // result: [62:0] unique_id, [64:63] status, rest zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tuid_pkg::M_DATA_BITS-1:0]  m_tdata
);
    import tuid_pkg::*;

    localparam logic [REQ_BITS-1:0] SLOT_LIMIT = REQ_BITS'(NUM_SLOTS);

    logic [WORKER_BITS-1:0] worker_reg;

    logic                   s_fire;
    logic [REQ_BITS-1:0]    s_slot;
    logic [TIME_BITS-1:0]   s_now;
    logic [SLOT_BITS-1:0]   s_sel;

    logic                   a_vld_reg;
    logic                   a_vld_next;
    logic [SLOT_BITS-1:0]   a_sel_reg;
    logic [TIME_BITS-1:0]   a_now_reg;
    logic                   a_adv;

    slot_entry_t            rd_entry;
    slot_entry_t            wr_entry;
    logic                   wr_en;
    logic                   same_ms;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count_new;
    logic [ID_BITS-1:0]     id_val;

    logic                   m_vld_reg;
    logic                   m_vld_next;
    logic [ID_BITS-1:0]     m_id_reg;
    logic [STATUS_BITS-1:0] m_status_reg;

    // Hold the worker id
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_reg <= '0;
        end else if (cfg_we) begin
            worker_reg <= cfg_wdata;
        end
    end

    // Unpack the request and map out-of-range slots to slot 0
    assign s_slot = s_tdata[REQ_BITS-1:0];
    assign s_now  = s_tdata[REQ_BITS +: TIME_BITS];
    assign s_sel  = (s_slot < SLOT_LIMIT) ? s_slot[SLOT_BITS-1:0] : '0;

    // Advance the request stage when the result register is free
    assign a_adv    = a_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !a_vld_reg || a_adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        a_vld_next = a_vld_reg;
        if (s_fire) begin
            a_vld_next = 1'b1;
        end else if (a_adv) begin
            a_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_sel_reg <= s_sel;
            a_now_reg <= s_now;
        end
    end

    // Slot table, read on acceptance, written on a successful update
    tuid_slot_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (s_sel),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (a_sel_reg),
        .wr_data (wr_entry)
    );

    // Compare the time, update the count and build the id
    always_comb begin
        same_ms   = (a_now_reg == rd_entry.last_time);
        count_new = '0;
        if (a_now_reg < rd_entry.last_time) begin
            status = ST_BEHIND;
        end else if (same_ms && (rd_entry.count == COUNT_MAX)) begin
            status = ST_EXHAUSTED;
        end else begin
            status = ST_OK;
            if (same_ms) begin
                count_new = rd_entry.count + 1'b1;
            end
        end
        wr_entry.last_time = a_now_reg;
        wr_entry.count     = count_new;
        id_val = '0;
        if (status == ST_OK) begin
            id_val = ID_BITS'({a_now_reg, worker_reg, count_new});
        end
    end

    assign wr_en = a_adv && (status == ST_OK);

    // Result register
    always_comb begin
        m_vld_next = m_vld_reg;
        if (a_adv) begin
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            m_id_reg     <= id_val;
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = M_DATA_BITS'({m_status_reg, m_id_reg});

endmodule

// File: sv/tuid_checker.sv
// Port-level checks of the time-ordered unique id generator.
// Depends on tuid_pkg; bound to the top level at the end of this file.
module tuid_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tuid_pkg::M_DATA_BITS-1:0]  m_tdata
);
    import tuid_pkg::*;

    logic [STATUS_BITS-1:0] m_status;
    logic [ID_BITS-1:0]     m_id;

    assign m_status = m_tdata[ID_BITS +: STATUS_BITS];
    assign m_id     = m_tdata[ID_BITS-1:0];

    // Stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Only defined status codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_status == ST_OK) || (m_status == ST_BEHIND)
                     || (m_status == ST_EXHAUSTED))
        else $error("undefined status code");

    // Retry status carries a zero id
    a_retry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_status != ST_OK) |-> (m_id == '0))
        else $error("nonzero id with retry status");

    // A result word that shows up on an empty output follows a request that passed through the request stage
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word appeared without a request");

endmodule

bind time_ordered_unique_id_generator tuid_checker u_tuid_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for time_ordered_unique_id_generator: directed corners,
// count exhaustion, worker id settings, random traffic and a long result stall.
// Depends on tuid_pkg and the generator RTL; ids are predicted in-line per request word.
module tb_top;
    import tuid_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RESET_CYCLES = 8;
    localparam int PRINT_LIMIT = 40;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [WORKER_BITS-1:0] WORKER_MAX = '1;

    typedef struct packed {
        logic [ID_BITS-1:0]     id;
        logic [STATUS_BITS-1:0] status;
    } id_result_t;

    // DUT ports
    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [WORKER_BITS-1:0] cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;     // [7:0] counter_slot, [48:8] now_ms, rest zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;          // [62:0] unique_id, [64:63] status, rest zero

    // Predictor state: slot table and worker id as the block should hold them
    logic [TIME_BITS-1:0]   model_last_time [NUM_SLOTS];
    logic [COUNT_BITS-1:0]  model_count [NUM_SLOTS];
    logic [WORKER_BITS-1:0] model_worker_id;
    id_result_t             expected_ids [$];

    // Stimulus state: per-slot time the request source believes in
    logic [TIME_BITS-1:0]   source_time [NUM_SLOTS];
    logic [REQ_BITS-1:0]    hot_slots [4];

    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_request = 0;

    time_ordered_unique_id_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Map a requested slot onto a table index; out-of-range requests share slot 0
    function automatic int slot_of(logic [REQ_BITS-1:0] slot_req);
        if (slot_req > 0 && slot_req < NUM_SLOTS)
            return int'(slot_req);
        return 0;
    endfunction

    // Work out the id for one request and update the predicted slot table
    function automatic id_result_t predict_id(logic [REQ_BITS-1:0] slot_req,
                                              logic [TIME_BITS-1:0] now);
        id_result_t            r;
        int                    s;
        logic [COUNT_BITS-1:0] next_count;
        logic [63:0]           packed_id;
        s = slot_of(slot_req);
        r.id = '0;
        r.status = ST_OK;
        if (now < model_last_time[s]) begin
            r.status = ST_BEHIND;
        end else if (now == model_last_time[s] && model_count[s] == COUNT_MAX) begin
            r.status = ST_EXHAUSTED;
        end else begin
            if (now == model_last_time[s]) begin
                next_count = model_count[s] + 1'b1;
            end else begin
                next_count = '0;
                model_last_time[s] = now;
            end
            model_count[s] = next_count;
            packed_id = (64'(now) << (COUNT_BITS + WORKER_BITS))
                      | (64'(model_worker_id) << COUNT_BITS)
                      | 64'(next_count);
            r.id = packed_id[ID_BITS-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Predict on every accepted request word, check every accepted result word
    always @(posedge aclk) begin : word_monitor
        id_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_ids.size() == 0) begin
                    report_mismatch("unexpected result word", 64'(m_tdata), 64'd0);
                end else begin
                    want = expected_ids.pop_front();
                    if (m_tdata[ID_BITS-1:0] !== want.id)
                        report_mismatch("unique_id", 64'(m_tdata[ID_BITS-1:0]), 64'(want.id));
                    if (m_tdata[ID_BITS +: STATUS_BITS] !== want.status)
                        report_mismatch("status", 64'(m_tdata[ID_BITS +: STATUS_BITS]),
                                        64'(want.status));
                    if (m_tdata[M_DATA_BITS-1:M_FIELD_BITS] !== '0)
                        report_mismatch("padding", 64'(m_tdata[M_DATA_BITS-1:M_FIELD_BITS]),
                                        64'd0);
                end
            end
            if (s_tvalid && s_tready)
                expected_ids.push_back(predict_id(s_tdata[REQ_BITS-1:0],
                                                  s_tdata[REQ_BITS +: TIME_BITS]));
        end
    end

    // Result sink: random stalls, plus a long hold when one is requested
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("time_ordered_unique_id_generator test failed");
        $finish;
    end

    // Offer one request word, with an optional idle gap first; return once accepted
    task automatic send_request(logic [REQ_BITS-1:0] slot_req, logic [TIME_BITS-1:0] now);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_BITS'({now, slot_req});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Request with a plausible clock: mostly the same or up to three milliseconds later, mostly on four hot slots
    task automatic send_random_request();
        logic [REQ_BITS-1:0]  slot_req;
        logic [TIME_BITS-1:0] now;
        int                   s;
        int                   r;
        if ($urandom_range(0, 99) < 65)
            slot_req = hot_slots[$urandom_range(0, 3)];
        else
            slot_req = REQ_BITS'($urandom_range(0, 255));
        s = slot_of(slot_req);
        r = $urandom_range(0, 99);
        if (r < 50)
            now = source_time[s];
        else if (r < 80)
            now = source_time[s] + TIME_BITS'($urandom_range(1, 3));
        else if (r < 93)
            now = source_time[s] - TIME_BITS'($urandom_range(1, 5));
        else
            now = TIME_BITS'({$urandom(), $urandom()});
        if (now > source_time[s])
            source_time[s] = now;
        send_request(slot_req, now);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_ids.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_worker_id(logic [WORKER_BITS-1:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        model_worker_id = value;
    endtask

    // Field extremes, slot aliasing, same and later millisecond, clock behind
    task automatic test_directed_corners();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(8'd0, 41'd0);
        send_request(8'd0, 41'd0);
        send_request(8'd128, 41'd0);
        send_request(8'd255, 41'd0);
        send_request(8'd1, 41'd0);
        send_request(8'd127, TIME_MAX);
        send_request(8'd127, TIME_MAX);
        send_request(8'd127, 41'd0);
        send_request(8'd127, TIME_MAX - 1'b1);
        send_request(8'd64, 41'd5);
        send_request(8'd64, 41'd5);
        send_request(8'd64, 41'd6);
        send_request(8'd64, 41'd4);
        send_request(8'd0, 41'd1);
        send_request(8'd200, 41'd1);
        send_request(8'h55, 41'h155_5555_5555);
        send_request(8'hAA, 41'h0AA_AAAA_AAAA);
        send_request(8'hAA, 41'h0AA_AAAA_AAAA);
        send_request(8'h2A, 41'h0AA_AAAA_AAAA);
        send_request(8'h55, 41'h0AA_AAAA_AAAA);
    endtask

    // Worker id extremes and a mixed pattern land in bits 21..12
    task automatic test_worker_id();
        logic [WORKER_BITS-1:0] settings [3];
        settings[0] = WORKER_MAX;
        settings[1] = 10'h155;
        settings[2] = '0;
        foreach (settings[i]) begin
            write_worker_id(settings[i]);
            send_request(8'd3, 41'd1000 + i);
            send_request(8'd3, 41'd1000 + i);
            send_request(8'd130, TIME_MAX);
        end
    endtask

    // Use up all counts of one millisecond, then see retry, behind and the next millisecond
    task automatic test_count_exhaustion();
        logic [TIME_BITS-1:0] t;
        t = 41'h1_2345_6789;
        write_worker_id(10'h2C3);
        tx_idle_pct = 5;
        rx_idle_pct = 5;
        repeat (1 << COUNT_BITS) send_request(8'd9, t);
        send_request(8'd9, t);
        send_request(8'd9, t);
        send_request(8'd9, t - 1'b1);
        send_request(8'd9, t + 1'b1);
        send_request(8'd9, t + 1'b1);
    endtask

    // Random traffic over several worker ids and idle mixes
    task automatic test_random_traffic(int items_per_phase);
        int tx_mix [5];
        int rx_mix [5];
        tx_mix = '{0, 30, 10, 50, 20};
        rx_mix = '{0, 30, 50, 10, 20};
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: write_worker_id(WORKER_MAX);
                2: write_worker_id('0);
                default: write_worker_id(WORKER_BITS'($urandom_range(1, 1022)));
            endcase
            tx_idle_pct = tx_mix[p];
            rx_idle_pct = rx_mix[p];
            repeat (items_per_phase) send_random_request();
        end
    endtask

    // Hold the result side for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 300;
        repeat (60) send_random_request();
        rx_idle_pct = 20;
        repeat (40) send_random_request();
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            model_last_time[i] = '0;
            model_count[i] = '0;
            source_time[i] = '0;
        end
        model_worker_id = '0;
        hot_slots[0] = 8'd0;
        hot_slots[1] = 8'd1;
        hot_slots[2] = 8'd127;
        hot_slots[3] = REQ_BITS'($urandom_range(2, 126));

        // Synchronous reset, released at a falling edge
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_worker_id();
        test_count_exhaustion();
        test_random_traffic(380);
        test_result_backpressure();

        drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("time_ordered_unique_id_generator test passed");
        else
            $display("time_ordered_unique_id_generator test failed");
        $finish;
    end

endmodule
